// ===== hdl/rc4_pkg.sv =====
// shared types and constants for the rc4 stream cipher
// no dependencies; imported by rc4_sbox and rc4_stream_cipher
`timescale 1ns / 1ps
`default_nettype none

package rc4_pkg;

    localparam int BYTE_W    = 8;
    localparam int SBOX_SIZE = 256;
    localparam int SB_AW     = 8;

    typedef logic [BYTE_W-1:0] t_byte;

    // command codes carried in tuser
    localparam logic CMD_KEY  = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    // one s-box request: an optional write, one read, optional clear
    typedef struct packed {
        logic             clr;
        logic             we;
        logic [SB_AW-1:0] waddr;
        t_byte            wdata;
        logic [SB_AW-1:0] raddr;
    } t_sbox_req;

endpackage

`default_nettype wire

// ===== hdl/rc4_ram.sv =====
// generic simple dual-port ram: one write port, one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== hdl/rc4_sbox.sv =====
// rc4 s-box: 256-byte ram plus one valid bit per entry
// an entry never written since reset or clear reads as its own index
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps
`default_nettype none

module rc4_sbox (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire rc4_pkg::t_sbox_req i_req,
    output rc4_pkg::t_byte        o_rdata
);
    import rc4_pkg::*;

    logic [SBOX_SIZE-1:0] r_valid;
    logic [SB_AW-1:0]     r_rd_addr;
    logic                 r_rd_valid;
    t_byte                ram_q;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_req.we),
        .i_waddr (i_req.waddr),
        .i_wdata (i_req.wdata),
        .i_raddr (i_req.raddr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.clr) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.waddr] <= 1'b1;
        end
        r_rd_addr  <= i_req.raddr;
        r_rd_valid <= r_valid[i_req.raddr];
    end

    // identity permutation stands in for unwritten entries
    assign o_rdata = r_rd_valid ? ram_q : t_byte'(r_rd_addr);

endmodule

`default_nettype wire

// ===== hdl/rc4_stream_cipher.sv =====
// rc4 stream cipher top level: key store, sequencer and output register
// depends on rc4_pkg, rc4_sbox and rc4_ram
`timescale 1ns / 1ps
`default_nettype none

// Byte-wide RC4 engine. Input words carry a key byte (tuser = 0) or a data
// byte (tuser = 1); tlast on a key word starts the key schedule over the key
// bytes collected so far (up to KEY_DEPTH, later ones are dropped), tlast on
// a data word restarts the keystream indices after that byte while keeping
// the s-box. A key word without tlast leaves the block ready for the next
// word. On the final key word each schedule round reads S[n], then S[j],
// then writes both entries one after the other through the single write port
// of the s-box ram. A data word goes from acceptance to its result in the
// output register through reads of S[i], S[j], swap writes overlapped with
// the read of S[t], and a wait while the previous result still waits on the
// output side; the input is ready again as soon as the result is loaded,
// while that result may still wait on the output side. After reset the
// s-box is the identity and the block is ready at once.

module rc4_stream_cipher #(
    parameter int KEY_DEPTH = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [15:0] i_s_axis_tdata,   // key_byte [7:0], data_byte [15:8]
    input  wire logic [0:0]  i_s_axis_tuser,   // command [0]
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [7:0]       o_m_axis_tdata,   // out_byte [7:0]
    output logic             o_m_axis_tlast
);
    import rc4_pkg::*;

    localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
    localparam int KCW = $clog2(KEY_DEPTH + 1);
    localparam logic [KCW-1:0] KEY_FULL = KCW'(KEY_DEPTH);
    localparam logic [SB_AW-1:0] LAST_ROUND = SB_AW'(SBOX_SIZE - 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KS_RDN,
        ST_KS_RDJ,
        ST_KS_WRN,
        ST_KS_WRJ,
        ST_DS_RDI,
        ST_DS_RDJ,
        ST_DS_WRI,
        ST_DS_WRJ,
        ST_DS_OUT
    } t_state;

    t_state           r_state;
    logic [KCW-1:0]   r_kcnt;
    logic [KAW-1:0]   r_kidx;
    logic [SB_AW-1:0] r_n;
    logic [SB_AW-1:0] r_i;
    logic [SB_AW-1:0] r_j;
    logic [SB_AW-1:0] r_t;
    t_byte            r_sa;
    t_byte            r_sb;
    t_byte            r_d;
    logic             r_last;
    t_byte            r_ks;
    logic             r_ovalid;
    t_byte            r_odata;
    logic             r_olast;

    logic             s_acc;
    logic             s_cmd;
    t_byte            s_key;
    t_byte            s_data;
    logic             key_we;
    t_byte            key_q;
    t_byte            kb;
    t_byte            s_rd;
    t_sbox_req        sb_req;
    logic [SB_AW-1:0] n_j;
    logic [SB_AW-1:0] n_t;
    logic [KAW-1:0]   n_kidx;
    t_byte            n_st;
    logic             out_free;
    logic             out_load;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign s_cmd  = i_s_axis_tuser[0];
    assign s_key  = i_s_axis_tdata[7:0];
    assign s_data = i_s_axis_tdata[15:8];
    assign key_we = s_acc && (s_cmd == CMD_KEY) && (r_kcnt < KEY_FULL);
    assign out_free = !r_ovalid || i_m_axis_tready;
    assign out_load = (r_state == ST_DS_OUT) && out_free;

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (r_kcnt[KAW-1:0]),
        .i_wdata (s_key),
        .i_raddr (r_kidx),
        .o_rdata (key_q)
    );

    rc4_sbox u_sbox (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sb_req),
        .o_rdata (s_rd)
    );

    always_comb begin
        kb = (r_kcnt == '0) ? '0 : key_q;
        n_t = r_sa + s_rd;
        // key index wraps at the counted key length
        n_kidx = ((KCW'(r_kidx) + KCW'(1)) == r_kcnt) ? '0 : r_kidx + KAW'(1);
        // S[t] after the swap: forward the swapped values
        if (r_t == r_j) begin
            n_st = r_sa;
        end else if (r_t == r_i) begin
            n_st = r_sb;
        end else begin
            n_st = s_rd;
        end
        unique case (r_state)
            ST_KS_RDJ: n_j = r_j + s_rd + kb;
            ST_DS_RDJ: n_j = r_j + s_rd;
            default:   n_j = r_j;
        endcase
    end

    always_comb begin
        sb_req       = '0;
        sb_req.raddr = r_n;
        unique case (r_state)
            ST_IDLE: begin
                sb_req.clr = s_acc && (s_cmd == CMD_KEY) && i_s_axis_tlast;
            end
            ST_KS_RDN: sb_req.raddr = r_n;
            ST_KS_RDJ: sb_req.raddr = n_j;
            ST_KS_WRN: begin
                sb_req.we    = 1'b1;
                sb_req.waddr = r_n;
                sb_req.wdata = s_rd;
            end
            ST_KS_WRJ: begin
                sb_req.we    = 1'b1;
                sb_req.waddr = r_j;
                sb_req.wdata = r_sa;
            end
            ST_DS_RDI: sb_req.raddr = r_i;
            ST_DS_RDJ: sb_req.raddr = n_j;
            ST_DS_WRI: begin
                sb_req.we    = 1'b1;
                sb_req.waddr = r_i;
                sb_req.wdata = s_rd;
                sb_req.raddr = n_t;
            end
            ST_DS_WRJ: begin
                sb_req.we    = 1'b1;
                sb_req.waddr = r_j;
                sb_req.wdata = r_sa;
            end
            ST_DS_OUT: sb_req.raddr = r_n;
            default:   sb_req.raddr = r_n;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_kcnt   <= '0;
            r_i      <= '0;
            r_j      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        if (s_cmd == CMD_KEY) begin
                            if (key_we) begin
                                r_kcnt <= r_kcnt + KCW'(1);
                            end
                            if (i_s_axis_tlast) begin
                                r_n     <= '0;
                                r_j     <= '0;
                                r_kidx  <= '0;
                                r_state <= ST_KS_RDN;
                            end
                        end else begin
                            r_i     <= r_i + SB_AW'(1);
                            r_d     <= s_data;
                            r_last  <= i_s_axis_tlast;
                            r_state <= ST_DS_RDI;
                        end
                    end
                end
                ST_KS_RDN: r_state <= ST_KS_RDJ;
                ST_KS_RDJ: begin
                    r_j     <= n_j;
                    r_sa    <= s_rd;
                    r_state <= ST_KS_WRN;
                end
                ST_KS_WRN: r_state <= ST_KS_WRJ;
                ST_KS_WRJ: begin
                    r_kidx <= n_kidx;
                    r_n    <= r_n + SB_AW'(1);
                    if (r_n == LAST_ROUND) begin
                        r_kcnt  <= '0;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= ST_IDLE;
                    end else begin
                        r_state <= ST_KS_RDN;
                    end
                end
                ST_DS_RDI: r_state <= ST_DS_RDJ;
                ST_DS_RDJ: begin
                    r_j     <= n_j;
                    r_sa    <= s_rd;
                    r_state <= ST_DS_WRI;
                end
                ST_DS_WRI: begin
                    r_sb    <= s_rd;
                    r_t     <= n_t;
                    r_state <= ST_DS_WRJ;
                end
                ST_DS_WRJ: begin
                    r_ks    <= r_d ^ n_st;
                    r_state <= ST_DS_OUT;
                end
                ST_DS_OUT: begin
                    if (out_load) begin
                        r_odata  <= r_ks;
                        r_olast  <= r_last;
                        if (r_last) begin
                            r_i <= '0;
                            r_j <= '0;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

    // final key word starts the schedule on the next cycle
    a_sched_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_cmd == CMD_KEY) && i_s_axis_tlast) |=> (r_state == ST_KS_RDN))
        else $error("key schedule did not start");

    a_key_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kcnt <= KEY_FULL)
        else $error("key count beyond key depth");

    // end of schedule leaves indices and key count cleared
    a_sched_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_KS_WRJ) && (r_n == LAST_ROUND))
        |=> ((r_i == '0) && (r_j == '0) && (r_kcnt == '0) && (r_state == ST_IDLE)))
        else $error("schedule did not finish cleanly");

    // a result is loaded whenever the output register is free
    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_DS_OUT) && out_free) |=> (o_m_axis_tvalid && (r_state == ST_IDLE)))
        else $error("result not loaded");

    // the input side is closed while a data word is in flight
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && (s_cmd == CMD_DATA)) |=> (!o_s_axis_tready ##3 !o_s_axis_tready))
        else $error("input accepted during a keystream step");

endmodule

`default_nettype wire
